>>> design/hif_pkg.sv
// ---------------------------------------------------------------------------
// hif_pkg
// Shared widths, beat types and limits for the HLL interface flux block.
// ---------------------------------------------------------------------------
`default_nettype none

package hif_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned FRAC_BITS  = 16;

  // bounds, differences and sums: one guard bit
  localparam int unsigned LW = DATA_WIDTH + 1;
  // product of two LW operands and their sum
  localparam int unsigned PW = 2 * LW;
  localparam int unsigned AW = PW + 1;
  // high part of lmax*lmin times du
  localparam int unsigned HW = (PW - DATA_WIDTH) + LW;
  // full numerator and its magnitude
  localparam int unsigned NW_A = 3 * DATA_WIDTH;
  localparam int unsigned NW_B = 2 * DATA_WIDTH + 1 + FRAC_BITS;
  localparam int unsigned NW   = ((NW_A > NW_B) ? NW_A : NW_B) + 1;
  localparam int unsigned MW   = NW - 1;
  // divisor, remainder and compare widths
  localparam int unsigned DW = LW + FRAC_BITS;
  localparam int unsigned RW = DW + DATA_WIDTH;
  localparam int unsigned CW = (MW > RW) ? MW : RW;
  // quotient bits plus the rounding bit
  localparam int unsigned QW = DATA_WIDTH + 1;
  localparam int unsigned NCELL = QW;
  // start accept to done strobe: six front stages, the cells, the output
  localparam int unsigned LATENCY = 6 + NCELL + 1;

  localparam logic [QW-1:0] LIM_POS = {2'b00, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [QW-1:0] LIM_NEG = {2'b01, {(DATA_WIDTH-1){1'b0}}};

  localparam logic signed [DATA_WIDTH-1:0] CORR_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] CORR_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] out_speed_int;
    logic signed [DATA_WIDTH-1:0] in_speed_int;
    logic signed [DATA_WIDTH-1:0] out_speed_ext;
    logic signed [DATA_WIDTH-1:0] in_speed_ext;
    logic signed [DATA_WIDTH-1:0] state_int;
    logic signed [DATA_WIDTH-1:0] flux_int;
    logic signed [DATA_WIDTH-1:0] state_ext;
    logic signed [DATA_WIDTH-1:0] flux_ext;
  } hif_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] correction;
    logic                         saturated;
  } hif_res_t;

  // beat handed from cell to cell in the divider chain
  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic [RW-1:0] rem;
    logic [RW-1:0] dsh;
    logic [QW-1:0] quo;
  } hif_div_t;

endpackage

`default_nettype wire

>>> design/hif_front.sv
// ---------------------------------------------------------------------------
// hif_front
// Wave-speed bounds, exact numerator products and divider setup, six stages.
// ---------------------------------------------------------------------------
`default_nettype none

module hif_front
  import hif_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  input  wire logic     weak_i,
  input  wire hif_in_t  in_i,
  output logic          valid_o,
  output hif_div_t      div_o
);

  logic [5:0] vld_q, vld_d;

  // stage 1: bounds and multiplier operands
  logic signed [LW-1:0] osi, isi, nose, nise, fi, fe, si, se, fs;
  logic signed [LW-1:0] lmax_d, lmin_d, du_d, ma_d, mb_d, mc_d, md_d;
  logic        [LW-1:0] dl_d;
  logic signed [LW-1:0] lmax_q, lmin_q, du1_q, ma_q, mb_q, mc_q, md_q;
  logic        [LW-1:0] dl1_q;

  // stage 2: products
  logic signed [PW-1:0] m1_d, m2_d, pml_d;
  logic signed [PW-1:0] m1_q, m2_q, pml_q;
  logic signed [LW-1:0] du2_q;
  logic        [LW-1:0] dl2_q;

  // stage 3: flux term and split product with du
  logic signed [AW-1:0] a_d, a_q;
  logic signed [PW-1:0] pl_d, pl_q;
  logic signed [HW-1:0] ph_d, ph_q;
  logic        [LW-1:0] dl3_q;

  // stage 4: numerator
  logic signed [NW-1:0] num_d, num_q;
  logic        [LW-1:0] dl4_q;

  // stage 5: magnitude
  logic signed [NW-1:0] num_neg;
  logic        [MW-1:0] mag_d, mag_q;
  logic                 neg5_q;
  logic        [DW-1:0] den_d, den_q;

  // stage 6: overflow check and divider seed
  hif_div_t div_d, div_q;

  assign vld_d = {vld_q[4:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    osi  = LW'(in_i.out_speed_int);
    isi  = LW'(in_i.in_speed_int);
    nose = -LW'(in_i.out_speed_ext);
    nise = -LW'(in_i.in_speed_ext);
    fi   = LW'(in_i.flux_int);
    fe   = LW'(in_i.flux_ext);
    si   = LW'(in_i.state_int);
    se   = LW'(in_i.state_ext);
    fs   = fi + fe;
    du_d = se - si;

    lmax_d = '0;
    if (osi > lmax_d) begin
      lmax_d = osi;
    end
    if (nise > lmax_d) begin
      lmax_d = nise;
    end
    lmin_d = '0;
    if (isi < lmin_d) begin
      lmin_d = isi;
    end
    if (nose < lmin_d) begin
      lmin_d = nose;
    end

    dl_d = lmax_d - lmin_d;
    if (dl_d == '0) begin
      dl_d = LW'(1);
    end

    if (weak_i) begin
      ma_d = lmax_d;
      mb_d = fi;
      mc_d = lmin_d;
      md_d = fe;
    end else begin
      ma_d = lmin_d;
      mb_d = fs;
      mc_d = '0;
      md_d = '0;
    end
  end

  always_comb begin
    m1_d  = ma_q * mb_q;
    m2_d  = mc_q * md_q;
    pml_d = lmax_q * lmin_q;
  end

  always_comb begin
    a_d  = AW'(m1_q) + AW'(m2_q);
    pl_d = $signed({1'b0, pml_q[DATA_WIDTH-1:0]}) * du2_q;
    ph_d = $signed(pml_q[PW-1:DATA_WIDTH]) * du2_q;
  end

  always_comb begin
    num_d = (NW'(a_q) <<< FRAC_BITS) + (NW'(ph_q) <<< DATA_WIDTH) + NW'(pl_q);
  end

  always_comb begin
    num_neg = -num_q;
    mag_d   = num_q[NW-1] ? MW'(num_neg) : MW'(num_q);
    den_d   = {dl4_q, {FRAC_BITS{1'b0}}};
  end

  always_comb begin
    div_d.neg = neg5_q;
    div_d.ovf = CW'(mag_q) >= (CW'(den_q) << DATA_WIDTH);
    div_d.rem = RW'(mag_q);
    div_d.dsh = RW'(den_q) << (DATA_WIDTH - 1);
    div_d.quo = '0;
  end

  always_ff @(posedge clk_i) begin
    lmax_q <= lmax_d;
    lmin_q <= lmin_d;
    du1_q  <= du_d;
    dl1_q  <= dl_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    mc_q   <= mc_d;
    md_q   <= md_d;

    m1_q   <= m1_d;
    m2_q   <= m2_d;
    pml_q  <= pml_d;
    du2_q  <= du1_q;
    dl2_q  <= dl1_q;

    a_q    <= a_d;
    pl_q   <= pl_d;
    ph_q   <= ph_d;
    dl3_q  <= dl2_q;

    num_q  <= num_d;
    dl4_q  <= dl3_q;

    mag_q  <= mag_d;
    neg5_q <= num_q[NW-1];
    den_q  <= den_d;

    div_q  <= div_d;
  end

  assign valid_o = vld_q[5];
  assign div_o   = div_q;

endmodule

`default_nettype wire

>>> design/hif_div_cell.sv
// ---------------------------------------------------------------------------
// hif_div_cell
// One restoring-division cell: one quotient bit per beat, then hand it on.
// ---------------------------------------------------------------------------
`default_nettype none

module hif_div_cell
  import hif_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  input  wire hif_div_t div_i,
  output logic          valid_o,
  output hif_div_t      div_o
);

  logic          valid_q;
  hif_div_t      div_d, div_q;
  logic [RW:0]   diff;

  always_comb begin
    diff      = {1'b0, div_i.rem} - {1'b0, div_i.dsh};
    div_d     = div_i;
    div_d.quo = {div_i.quo[QW-2:0], ~diff[RW]};
    if (!diff[RW]) begin
      div_d.rem = diff[RW-1:0];
    end
    div_d.dsh = div_i.dsh >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

`default_nettype wire

>>> design/hll_interface_flux.sv
// ---------------------------------------------------------------------------
// hll_interface_flux
// HLL numerical flux for one conserved component at one interface point.
// ---------------------------------------------------------------------------
// Usage:
//   Input beat: drive in_i and raise start; it is taken at any edge with
//   start high (busy stays low, the pipeline takes a beat every cycle).
//   Result beat: done_o pulses for one cycle with res_o; there is no
//   backpressure, the receiver must take it in that cycle.
//   Pipeline: six front stages (bounds, products, numerator, magnitude,
//   range check), one divider cell per quotient bit plus one for
//   rounding, and the output register. Throughput: one beat per clock.
//   Configuration: cfg_we_i writes cfg_wdata_i into weak_form; write it
//   only while no beat is in flight. weak_form is 0 after reset.
//   Reset: rst_ni clears all valid flags and weak_form; beats in flight
//   are dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module hll_interface_flux
  import hif_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire hif_in_t  in_i,
  input  wire logic     cfg_we_i,
  input  wire logic     cfg_wdata_i,
  output logic          done_o,
  output hif_res_t      res_o
);

  logic             weak_q;
  logic [NCELL:0]   chain_vld;
  hif_div_t         chain_div [NCELL+1];

  logic [QW-1:0]    q_rnd, lim, q_sat, corr;
  logic             sat;
  logic             done_q;
  hif_res_t         res_d, res_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weak_q <= 1'b0;
    end else if (cfg_we_i) begin
      weak_q <= cfg_wdata_i;
    end
  end

  hif_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .weak_i  (weak_q),
    .in_i    (in_i),
    .valid_o (chain_vld[0]),
    .div_o   (chain_div[0])
  );

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    hif_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_vld[k]),
      .div_i   (chain_div[k]),
      .valid_o (chain_vld[k+1]),
      .div_o   (chain_div[k+1])
    );
  end

  // last quotient bit is the half-LSB compare: round half away from zero
  always_comb begin
    q_rnd = {1'b0, chain_div[NCELL].quo[QW-1:1]} + QW'(chain_div[NCELL].quo[0]);
    lim   = chain_div[NCELL].neg ? LIM_NEG : LIM_POS;
    sat   = chain_div[NCELL].ovf || (q_rnd > lim);
    q_sat = sat ? lim : q_rnd;
    corr  = chain_div[NCELL].neg ? (QW'(0) - q_sat) : q_sat;
    res_d.correction = corr[DATA_WIDTH-1:0];
    res_d.saturated  = sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain_vld[NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("accepted beat did not complete after fixed latency");

  a_latency_bwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result beat without matching accepted input");

  a_sat_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.saturated) |->
      (res_o.correction == CORR_MAX || res_o.correction == CORR_MIN))
    else $error("saturated result is not at a range limit");

endmodule

`default_nettype wire

>>> dv/tb_hll_interface_flux.sv
// ---------------------------------------------------------------------------
// tb_hll_interface_flux
// Self-checking bench for the HLL interface flux block. Input beats are
// predicted with exact 128-bit arithmetic, and each result beat is checked in
// order against the oldest prediction. The run covers both flux forms and
// several sender idle rates.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_hll_interface_flux;
  timeunit 1ns;
  timeprecision 1ps;
  import hif_pkg::*;

  class flux_scoreboard;
    hif_res_t    flux_q[$];
    logic        weak_form;
    int unsigned errors;
    int unsigned checked;
    int unsigned n_sat;

    function new();
      weak_form = 1'b0;
      errors    = 0;
      checked   = 0;
      n_sat     = 0;
    endfunction

    function hif_res_t hll_flux(hif_in_t x);
      logic signed [127:0] osi, isi, ose, ise, si, fi, se, fe;
      logic signed [127:0] lmax, lmin, dl, du, num;
      logic [127:0]        mag, den, quo, rem, lim;
      logic                neg;
      hif_res_t            r;
      osi = $signed(x.out_speed_int);
      isi = $signed(x.in_speed_int);
      ose = $signed(x.out_speed_ext);
      ise = $signed(x.in_speed_ext);
      si  = $signed(x.state_int);
      fi  = $signed(x.flux_int);
      se  = $signed(x.state_ext);
      fe  = $signed(x.flux_ext);
      lmax = '0;
      lmin = '0;
      if (osi > lmax) lmax = osi;
      if (-ise > lmax) lmax = -ise;
      if (isi < lmin) lmin = isi;
      if (-ose < lmin) lmin = -ose;
      dl = lmax - lmin;
      if (dl < 1) dl = 1;
      du = se - si;
      if (weak_form) num = lmax * fi + lmin * fe;
      else num = lmin * (fi + fe);
      num = (num <<< FRAC_BITS) + lmax * lmin * du;
      neg = (num < 0);
      mag = neg ? -num : num;
      den = dl << FRAC_BITS;
      quo = mag / den;
      rem = mag % den;
      // round half away from zero on the magnitude
      if ((rem << 1) >= den) quo = quo + 1;
      lim = (128'd1 << (DATA_WIDTH - 1)) - (neg ? 128'd0 : 128'd1);
      r.saturated = (quo > lim);
      if (r.saturated) quo = lim;
      r.correction = neg ? -quo[DATA_WIDTH-1:0] : quo[DATA_WIDTH-1:0];
      return r;
    endfunction

    function void note_beat(hif_in_t x);
      flux_q.push_back(hll_flux(x));
    endfunction

    function void check_result(hif_res_t got);
      hif_res_t want;
      if (flux_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with none pending: correction %h saturated %b",
                 $time, got.correction, got.saturated);
        return;
      end
      want = flux_q.pop_front();
      checked++;
      if (got.saturated) n_sat++;
      if (got.correction !== want.correction) begin
        errors++;
        $display("%0t: correction mismatch: expected %h actual %h",
                 $time, want.correction, got.correction);
      end
      if (got.saturated !== want.saturated) begin
        errors++;
        $display("%0t: saturated mismatch: expected %b actual %b",
                 $time, want.saturated, got.saturated);
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start;
  logic     busy;
  hif_in_t  in_i;
  logic     cfg_we_i;
  logic     cfg_wdata_i;
  logic     done_o;
  hif_res_t res_o;

  flux_scoreboard sb;
  int unsigned    idle_pct;

  hll_interface_flux u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .res_o       (res_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(res_o);
      if (start && !busy) sb.note_beat(in_i);
      if (cfg_we_i) sb.weak_form = cfg_wdata_i;
    end
  end

  function automatic hif_in_t mk_beat(logic [31:0] osi, logic [31:0] isi,
                                      logic [31:0] ose, logic [31:0] ise,
                                      logic [31:0] si, logic [31:0] fi,
                                      logic [31:0] se, logic [31:0] fe);
    return {osi, isi, ose, ise, si, fi, se, fe};
  endfunction

  // mix of extremes, zero and values of every magnitude
  function automatic logic [31:0] rand_word();
    case ($urandom_range(11))
      0: return '0;
      1: return CORR_MAX;
      2: return CORR_MIN;
      default: return $signed($urandom) >>> $urandom_range(31);
    endcase
  endfunction

  function automatic hif_in_t rand_beat();
    return mk_beat(rand_word(), rand_word(), rand_word(), rand_word(),
                   rand_word(), rand_word(), rand_word(), rand_word());
  endfunction

  task automatic send_beat(input hif_in_t x);
    start <= 1'b1;
    in_i  <= x;
    do @(posedge clk_i); while (busy);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // queue is looked at mid-cycle, clear of the edge where beats are noted
  task automatic drain();
    @(negedge clk_i);
    while (sb.flux_q.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_form(input logic w);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_directed();
    send_beat(mk_beat('0, '0, '0, '0, '0, '0, '0, '0));
    send_beat(mk_beat(CORR_MAX, CORR_MAX, CORR_MAX, CORR_MAX,
                      CORR_MAX, CORR_MAX, CORR_MAX, CORR_MAX));
    send_beat(mk_beat(CORR_MIN, CORR_MIN, CORR_MIN, CORR_MIN,
                      CORR_MIN, CORR_MIN, CORR_MIN, CORR_MIN));
    send_beat(mk_beat(CORR_MIN, CORR_MIN, CORR_MIN, CORR_MIN,
                      CORR_MAX, CORR_MAX, CORR_MAX, CORR_MAX));
    // zero bound spread, with zero and with nonzero speeds
    send_beat(mk_beat('0, '0, '0, '0, CORR_MAX, CORR_MIN, CORR_MIN, CORR_MAX));
    send_beat(mk_beat(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000,
                      32'h1234_5678, CORR_MAX, 32'h8765_4321, CORR_MIN));
    // halfway quotients, both signs
    send_beat(mk_beat(32'd1, 32'hFFFF_FFFF, '0, '0, '0, 32'd1, '0, '0));
    send_beat(mk_beat(32'd1, 32'hFFFF_FFFF, '0, '0, '0, 32'hFFFF_FFFF, '0, '0));
    // most negative exterior speeds negate to 2^31
    send_beat(mk_beat('0, '0, CORR_MIN, CORR_MIN, 32'h0001_0000, 32'h0002_0000,
                      32'h0003_0000, 32'hFFFF_0000));
    // clipping high and low
    send_beat(mk_beat(CORR_MAX, CORR_MIN, '0, '0, CORR_MAX, '0, CORR_MIN, '0));
    send_beat(mk_beat(CORR_MAX, CORR_MIN, '0, '0, CORR_MIN, '0, CORR_MAX, '0));
    send_beat(mk_beat(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000,
                      32'h0002_0000, 32'h0004_0000, 32'h0001_0000, 32'hFFFE_0000));
    start <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned n, input logic w, input int unsigned pct);
    set_form(w);
    idle_pct = pct;
    repeat (n) send_beat(rand_beat());
    start <= 1'b0;
  endtask

  initial begin
    sb          = new();
    idle_pct    = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    in_i        = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_form(1'b0);
    send_directed();
    set_form(1'b1);
    send_directed();

    run_phase(155, 1'b0, 0);
    run_phase(155, 1'b1, 83);
    run_phase(155, 1'b0, 21);
    run_phase(155, 1'b1, 0);
    run_phase(155, 1'b0, 83);
    run_phase(155, 1'b1, 21);

    drain();
    repeat (LATENCY + 8) @(posedge clk_i);

    $display("%0d flux beats checked across strong and weak form, %0d clipped",
             sb.checked, sb.n_sat);
    $display("sender idle rates of 0, 21 and 83 percent; %0d mismatches, %0d left pending",
             sb.errors, sb.flux_q.size());
    if (sb.errors == 0 && sb.flux_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout: run did not complete");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
